### src/tlik_pkg.sv
// ----------------------------------------------------------------------------
// tlik_pkg
// Types, constants and the arctangent table for the two-link leg solver.
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int LEN_W     = 14;
  localparam int COORD_W   = 16;
  localparam int HIP_W     = 17;
  localparam int KNEE_W    = 15;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ATAN_TAB_LEN        = 24;

  localparam int ZW          = 34;  // Q4.30 angle accumulator
  localparam int IN_W        = 34;  // cordic operand width
  localparam int XW          = 60;  // cordic vector width
  localparam int PRESCALE_SH = 24;
  localparam int ANG_FRAC    = 30;
  localparam int DIFF_W      = 35;

  localparam int SQ_STAGES = 29;    // root bits of a 58-bit radicand
  localparam int RAD_W     = 2 * SQ_STAGES;
  localparam int REM_W     = 31;

  localparam logic [LEN_W-1:0] LEN_RESET = 14'd1600;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic REG_UPPER = 1'b0;
  localparam logic REG_LOWER = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] foot_x;
    logic signed [COORD_W-1:0] foot_z;
  } item_t;

  typedef struct packed {
    logic signed [HIP_W-1:0] hip_angle;
    logic [KNEE_W-1:0]       knee_angle;
    logic                    reachable;
  } result_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 34'sd843314857;
      1:       v = 34'sd497837829;
      2:       v = 34'sd263043837;
      3:       v = 34'sd133525159;
      4:       v = 34'sd67021687;
      5:       v = 34'sd33543516;
      6:       v = 34'sd16775851;
      7:       v = 34'sd8388437;
      8:       v = 34'sd4194283;
      9:       v = 34'sd2097149;
      10:      v = 34'sd1048576;
      11:      v = 34'sd524288;
      12:      v = 34'sd262144;
      13:      v = 34'sd131072;
      14:      v = 34'sd65536;
      15:      v = 34'sd32768;
      16:      v = 34'sd16384;
      17:      v = 34'sd8192;
      18:      v = 34'sd4096;
      19:      v = 34'sd2048;
      20:      v = 34'sd1024;
      21:      v = 34'sd512;
      22:      v = 34'sd256;
      23:      v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half away from zero, dropping sh fraction bits
  function automatic logic signed [DIFF_W-1:0] round_angle(
    input logic signed [DIFF_W-1:0] a,
    input int                       sh
  );
    logic [DIFF_W-1:0] mag;
    logic [DIFF_W-1:0] half;
    logic [DIFF_W-1:0] r;
    half = DIFF_W'(1) << (sh - 1);
    mag  = (a < 0) ? DIFF_W'(-a) : DIFF_W'(a);
    r    = (mag + half) >> sh;
    return (a < 0) ? -$signed(r) : $signed(r);
  endfunction

endpackage

### src/tlik_cordic.sv
// ----------------------------------------------------------------------------
// tlik_cordic
// Pipelined vectoring CORDIC atan2(y, x), Q4.30 result; entry, iteration and output registers.
// ----------------------------------------------------------------------------
module tlik_cordic
  import tlik_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                   clk_i,
  input  logic signed [IN_W-1:0] y_i,
  input  logic signed [IN_W-1:0] x_i,
  output logic signed [ZW-1:0]   angle_o
);

  logic signed [XW-1:0] x_q [STAGES+1];
  logic signed [XW-1:0] y_q [STAGES+1];
  logic signed [ZW-1:0] z_q [STAGES+1];
  logic                 spec_q [STAGES+1];
  logic signed [ZW-1:0] sval_q [STAGES+1];
  logic                 ypos_q [STAGES+1];

  logic signed [XW-1:0] xe, ye, x_d, y_d;
  logic signed [ZW-1:0] z_d, sval_d, clamp_d;
  logic                 spec_d;
  logic signed [ZW-1:0] angle_q;

  // entry: scale, fold the left half plane, flag exact cases
  always_comb begin
    xe     = XW'(x_i) <<< PRESCALE_SH;
    ye     = XW'(y_i) <<< PRESCALE_SH;
    x_d    = xe;
    y_d    = ye;
    z_d    = '0;
    spec_d = 1'b0;
    sval_d = '0;
    if (xe < 0) begin
      if (ye > 0) begin
        x_d = ye;
        y_d = -xe;
        z_d = HALF_PI_Q30;
      end else begin
        x_d = -ye;
        y_d = xe;
        z_d = -HALF_PI_Q30;
      end
    end
    if (y_i == 0) begin
      spec_d = 1'b1;
      sval_d = (x_i < 0) ? PI_Q30 : '0;
    end else if (x_i == 0) begin
      spec_d = 1'b1;
      sval_d = (y_i > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x_d;
    y_q[0]    <= y_d;
    z_q[0]    <= z_d;
    spec_q[0] <= spec_d;
    sval_q[0] <= sval_d;
    ypos_q[0] <= (y_i > 0);
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [ZW-1:0] Atan = atan_tab(i);
    always_ff @(posedge clk_i) begin
      if (y_q[i] > 0) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + Atan;
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - Atan;
      end
      spec_q[i+1] <= spec_q[i];
      sval_q[i+1] <= sval_q[i];
      ypos_q[i+1] <= ypos_q[i];
    end
  end

  always_comb begin
    clamp_d = z_q[STAGES];
    if (ypos_q[STAGES]) begin
      if (clamp_d < 0) clamp_d = '0;
      if (clamp_d > PI_Q30) clamp_d = PI_Q30;
    end else begin
      if (clamp_d > 0) clamp_d = '0;
      if (clamp_d < -PI_Q30) clamp_d = -PI_Q30;
    end
    if (spec_q[STAGES]) clamp_d = sval_q[STAGES];
  end

  always_ff @(posedge clk_i) begin
    angle_q <= clamp_d;
  end

  assign angle_o = angle_q;

endmodule

### src/two_link_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics
// Hip and knee angles of a two-link leg for a foot target.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start / item_i (foot_x, foot_z, 1/16 mm) whenever busy is
//   low; busy never rises, one item per cycle. Each item yields one result on
//   result_o, marked by done_o for exactly one cycle, in entry order.
//   Each item passes through squares, reach test and products, a
//   one-bit-per-stage square root, three parallel CORDIC pipes, and
//   angle difference and rounding, in that order.
//   Thigh and shank lengths are written over the APB port (0x0 upper, 0x4
//   lower) and read back; write them only while no item is in flight.
//   Reset clears the pipeline valid bits and sets both lengths to 1600.
//   The receiver cannot stall: a result is valid for its single done_o cycle.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics
  import tlik_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  item_t             item_i,
  output logic              done_o,
  output result_t           result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int ROUND_SH = ANG_FRAC - ANGLE_FRAC_BITS;
  localparam int CL       = CORDIC_STAGES + 2;
  localparam int LATENCY  = 4 + SQ_STAGES + CL + 1;

  logic accept;
  logic [LEN_W-1:0] l1_q, l2_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start & ~busy;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= LEN_RESET;
      l2_q <= LEN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_UPPER: l1_q <= pwdata[LEN_W-1:0];
        REG_LOWER: l2_q <= pwdata[LEN_W-1:0];
        default:   l1_q <= l1_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_UPPER: prdata = DATA_W'(l1_q);
      REG_LOWER: prdata = DATA_W'(l2_q);
      default:   prdata = '0;
    endcase
  end

  // stage 1: squares and link products
  logic signed [COORD_W-1:0] fx, fz;
  logic signed [31:0]        xx, zz;
  logic [LEN_W:0]            lsum;
  logic [LEN_W-1:0]          ldif;

  assign fx   = item_i.foot_x;
  assign fz   = item_i.foot_z;
  assign xx   = fx * fx;
  assign zz   = fz * fz;
  assign lsum = {1'b0, l1_q} + {1'b0, l2_q};
  assign ldif = (l1_q >= l2_q) ? (l1_q - l2_q) : (l2_q - l1_q);

  logic                      v1_q;
  logic [30:0]               xx1_q, zz1_q;
  logic [27:0]               a1_q, b1_q, ab1_q, dd1_q;
  logic [29:0]               ss1_q;
  logic signed [COORD_W-1:0] x1_q, z1_q;

  always_ff @(posedge clk_i) begin
    xx1_q <= xx[30:0];
    zz1_q <= zz[30:0];
    a1_q  <= l1_q * l1_q;
    b1_q  <= l2_q * l2_q;
    ab1_q <= l1_q * l2_q;
    ss1_q <= lsum * lsum;
    dd1_q <= ldif * ldif;
    x1_q  <= fx;
    z1_q  <= fz;
  end

  // stage 2: reach test, cosine numerator and hip offset term
  logic [31:0]        dsq;
  logic [28:0]        p_d;
  logic signed [33:0] nraw, pe, m_d;
  logic signed [29:0] n_d;

  always_comb begin
    dsq  = {1'b0, xx1_q} + {1'b0, zz1_q};
    p_d  = {ab1_q, 1'b0};
    pe   = $signed({5'b0, p_d});
    nraw = $signed({2'b0, dsq}) - $signed({6'b0, a1_q}) - $signed({6'b0, b1_q});
    if (nraw > pe) nraw = pe;
    if (nraw < -pe) nraw = -pe;
    n_d = nraw[29:0];
    m_d = $signed({2'b0, dsq}) + $signed({6'b0, a1_q}) - $signed({6'b0, b1_q});
  end

  logic                      v2_q, r2_q;
  logic [28:0]               p2_q;
  logic signed [29:0]        n2_q;
  logic signed [33:0]        m2_q;
  logic signed [COORD_W-1:0] x2_q, z2_q;

  always_ff @(posedge clk_i) begin
    r2_q <= (dsq <= {2'b0, ss1_q}) && (dsq >= {4'b0, dd1_q});
    p2_q <= p_d;
    n2_q <= n_d;
    m2_q <= m_d;
    x2_q <= x1_q;
    z2_q <= z1_q;
  end

  // stage 3: squares for the sine term
  logic [28:0] nabs;
  assign nabs = (n2_q < 0) ? 29'(-n2_q) : 29'(n2_q);

  logic                      v3_q, r3_q;
  logic [RAD_W-1:0]          pp3_q, nn3_q;
  logic signed [29:0]        n3_q;
  logic signed [33:0]        m3_q;
  logic signed [COORD_W-1:0] x3_q, z3_q;

  always_ff @(posedge clk_i) begin
    pp3_q <= p2_q * p2_q;
    nn3_q <= nabs * nabs;
    r3_q  <= r2_q;
    n3_q  <= n2_q;
    m3_q  <= m2_q;
    x3_q  <= x2_q;
    z3_q  <= z2_q;
  end

  // square root, one root bit per stage
  logic [RAD_W-1:0]          rad_q  [SQ_STAGES+1];
  logic [REM_W-1:0]          rem_q  [SQ_STAGES+1];
  logic [SQ_STAGES-1:0]      root_q [SQ_STAGES+1];
  logic                      sv_q   [SQ_STAGES+1];
  logic                      sr_q   [SQ_STAGES+1];
  logic signed [29:0]        sn_q   [SQ_STAGES+1];
  logic signed [33:0]        sm_q   [SQ_STAGES+1];
  logic signed [COORD_W-1:0] sx_q   [SQ_STAGES+1];
  logic signed [COORD_W-1:0] sz_q   [SQ_STAGES+1];

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= pp3_q - nn3_q;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    sr_q[0]   <= r3_q;
    sn_q[0]   <= n3_q;
    sm_q[0]   <= m3_q;
    sx_q[0]   <= x3_q;
    sz_q[0]   <= z3_q;
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [REM_W+1:0] remx, trial;
    assign remx  = {rem_q[k], rad_q[k][RAD_W-1 -: 2]};
    assign trial = {2'b0, root_q[k], 2'b01};
    always_ff @(posedge clk_i) begin
      if (remx >= trial) begin
        rem_q[k+1]  <= REM_W'(remx - trial);
        root_q[k+1] <= {root_q[k][SQ_STAGES-2:0], 1'b1};
      end else begin
        rem_q[k+1]  <= remx[REM_W-1:0];
        root_q[k+1] <= {root_q[k][SQ_STAGES-2:0], 1'b0};
      end
      rad_q[k+1] <= rad_q[k] << 2;
      sr_q[k+1]  <= sr_q[k];
      sn_q[k+1]  <= sn_q[k];
      sm_q[k+1]  <= sm_q[k];
      sx_q[k+1]  <= sx_q[k];
      sz_q[k+1]  <= sz_q[k];
    end
  end

  // three atan2 pipes
  logic signed [IN_W-1:0] c_s, c_n, c_m, c_x, c_z;
  logic signed [ZW-1:0]   a_xz, a_sn, a_sm;

  assign c_s = $signed(IN_W'(root_q[SQ_STAGES]));
  assign c_n = IN_W'(sn_q[SQ_STAGES]);
  assign c_m = IN_W'(sm_q[SQ_STAGES]);
  assign c_x = IN_W'(sx_q[SQ_STAGES]);
  assign c_z = IN_W'(sz_q[SQ_STAGES]);

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_foot (
    .clk_i  (clk_i),
    .y_i    (c_x),
    .x_i    (c_z),
    .angle_o(a_xz)
  );

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_knee (
    .clk_i  (clk_i),
    .y_i    (c_s),
    .x_i    (c_n),
    .angle_o(a_sn)
  );

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_offs (
    .clk_i  (clk_i),
    .y_i    (c_s),
    .x_i    (c_m),
    .angle_o(a_sm)
  );

  logic cv_q [CL];
  logic cr_q [CL];

  always_ff @(posedge clk_i) begin
    cr_q[0] <= sr_q[SQ_STAGES];
    for (int j = 1; j < CL; j++) begin
      cr_q[j] <= cr_q[j-1];
    end
  end

  // final: hip difference, rounding of both angles, zero when unreachable
  logic signed [DIFF_W-1:0] hip_r, knee_r;
  assign hip_r  = round_angle(DIFF_W'(a_xz) - DIFF_W'(a_sm), ROUND_SH);
  assign knee_r = round_angle(DIFF_W'(a_sn), ROUND_SH);

  logic    done_q;
  result_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.reachable  <= cr_q[CL-1];
    res_q.hip_angle  <= cr_q[CL-1] ? hip_r[HIP_W-1:0] : '0;
    res_q.knee_angle <= cr_q[CL-1] ? knee_r[KNEE_W-1:0] : '0;
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
      for (int j = 0; j <= SQ_STAGES; j++) sv_q[j] <= 1'b0;
      for (int j = 0; j < CL; j++) cv_q[j] <= 1'b0;
    end else begin
      v1_q    <= accept;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      sv_q[0] <= v3_q;
      for (int j = 1; j <= SQ_STAGES; j++) sv_q[j] <= sv_q[j-1];
      cv_q[0] <= sv_q[SQ_STAGES];
      for (int j = 1; j < CL; j++) cv_q[j] <= cv_q[j-1];
      done_q  <= cv_q[CL-1];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("item did not complete after pipeline latency");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result without matching item");

  a_unreach_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.reachable) |->
      (result_o.hip_angle == 0 && result_o.knee_angle == 0))
    else $error("unreachable item with nonzero angles");

endmodule
